/* rtl/core/psw_pkg.sv */
// ---------------------------------------------------------------------------
// psw_pkg
// Shared types and fixed field widths for the priority schedule block.
// ---------------------------------------------------------------------------
package psw_pkg;

  // Fixed result field widths
  localparam int ID_W   = 5;
  localparam int WAIT_W = 21;
  localparam int TOTW_W = 25;
  localparam int TOTT_W = 26;
  // Running sums are kept modulo 2**ACC_W, enough for every result field
  localparam int ACC_W  = 26;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // store the accepted request
    logic emit;   // move the head job into the result register
  } psw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_one;  // one job left in the ordered store
  } psw_status_t;

endpackage

/* rtl/core/psw_ctrl.sv */
// ---------------------------------------------------------------------------
// psw_ctrl
// Load / emit sequencer and result valid flag.
// ---------------------------------------------------------------------------
module psw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last_job,
  input  logic                 out_stall,
  input  psw_pkg::psw_status_t status,
  output logic                 in_stall,
  output logic                 out_valid,
  output psw_pkg::psw_cmd_t    cmd
);

  psw_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            in_acc;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psw_pkg::ST_LOAD: begin
        if (in_valid && last_job) state_next = psw_pkg::ST_EMIT;
      end
      psw_pkg::ST_EMIT: begin
        if (out_free && status.last_one) state_next = psw_pkg::ST_LOAD;
      end
      default: state_next = psw_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    in_acc   = 1'b0;
    cmd      = '0;
    case (state)
      psw_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        cmd.load = in_acc;
      end
      psw_pkg::ST_EMIT: begin
        cmd.emit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_next = 1'b1;
    else          out_valid_next = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psw_pkg::ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/core/psw_dp.sv */
// ---------------------------------------------------------------------------
// psw_dp
// Ordered job store (insertion cells), running sums and result register.
// ---------------------------------------------------------------------------
module psw_dp #(
  parameter int MAX_PROCS  = 32,
  parameter int BURST_BITS = 16,
  parameter int PRIO_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  psw_pkg::psw_cmd_t           cmd,
  input  logic [BURST_BITS-1:0]       burst_time,
  input  logic [PRIO_BITS-1:0]        job_priority,
  output psw_pkg::psw_status_t        status,
  output logic [psw_pkg::ID_W-1:0]    job_id,
  output logic [PRIO_BITS-1:0]        out_priority,
  output logic [BURST_BITS-1:0]       out_burst,
  output logic [psw_pkg::WAIT_W-1:0]  wait_time,
  output logic [psw_pkg::WAIT_W-1:0]  turnaround,
  output logic [psw_pkg::TOTW_W-1:0]  total_wait,
  output logic [psw_pkg::TOTT_W-1:0]  total_turnaround,
  output logic                        overflow,
  output logic                        last_result
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int IDE_W = (IDX_W > psw_pkg::ID_W) ? IDX_W : psw_pkg::ID_W;

  // ordered store, head at cell 0
  logic [PRIO_BITS-1:0]  prio_q  [MAX_PROCS];
  logic [BURST_BITS-1:0] burst_q [MAX_PROCS];
  logic [IDX_W-1:0]      id_q    [MAX_PROCS];
  logic [MAX_PROCS-1:0]  gt;

  logic [CNT_W-1:0]         job_count;
  logic                     dropped_flag;
  logic [psw_pkg::ACC_W-1:0] wait_accum, totw_accum, tott_accum;
  logic [psw_pkg::ACC_W-1:0] turn_cur, totw_cur, tott_cur;
  logic                     full;
  logic                     store_en;
  logic [IDE_W-1:0]         head_id;

  assign full           = (job_count == CNT_W'(MAX_PROCS));
  assign store_en       = cmd.load && !full;
  assign status.last_one = (job_count == CNT_W'(1));

  // cell i lies behind the insertion point: empty, or strictly larger priority
  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      gt[i] = (CNT_W'(i) >= job_count) || (prio_q[i] > job_priority);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      always_ff @(posedge clk) begin
        if (store_en) begin
          if (g == 0) begin
            if (gt[g]) begin
              prio_q[g]  <= job_priority;
              burst_q[g] <= burst_time;
              id_q[g]    <= job_count[IDX_W-1:0];
            end
          end else if (gt[g] && !gt[(g == 0) ? 0 : g-1]) begin
            prio_q[g]  <= job_priority;
            burst_q[g] <= burst_time;
            id_q[g]    <= job_count[IDX_W-1:0];
          end else if (gt[g]) begin
            prio_q[g]  <= prio_q[(g == 0) ? 0 : g-1];
            burst_q[g] <= burst_q[(g == 0) ? 0 : g-1];
            id_q[g]    <= id_q[(g == 0) ? 0 : g-1];
          end
        end else if (cmd.emit && (g < MAX_PROCS - 1)) begin
          prio_q[g]  <= prio_q[(g < MAX_PROCS - 1) ? g+1 : g];
          burst_q[g] <= burst_q[(g < MAX_PROCS - 1) ? g+1 : g];
          id_q[g]    <= id_q[(g < MAX_PROCS - 1) ? g+1 : g];
        end
      end
    end
  endgenerate

  // head job figures
  assign turn_cur = wait_accum + psw_pkg::ACC_W'(burst_q[0]);
  assign totw_cur = totw_accum + wait_accum;
  assign tott_cur = tott_accum + turn_cur;
  assign head_id  = IDE_W'(id_q[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count    <= '0;
      dropped_flag <= 1'b0;
      wait_accum   <= '0;
      totw_accum   <= '0;
      tott_accum   <= '0;
    end else if (cmd.load) begin
      if (full) dropped_flag <= 1'b1;
      else      job_count    <= job_count + CNT_W'(1);
    end else if (cmd.emit) begin
      if (status.last_one) begin
        job_count    <= '0;
        dropped_flag <= 1'b0;
        wait_accum   <= '0;
        totw_accum   <= '0;
        tott_accum   <= '0;
      end else begin
        job_count  <= job_count - CNT_W'(1);
        wait_accum <= turn_cur;
        totw_accum <= totw_cur;
        tott_accum <= tott_cur;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      job_id       <= head_id[psw_pkg::ID_W-1:0];
      out_priority <= prio_q[0];
      out_burst    <= burst_q[0];
      wait_time    <= wait_accum[psw_pkg::WAIT_W-1:0];
      turnaround   <= turn_cur[psw_pkg::WAIT_W-1:0];
      overflow     <= dropped_flag;
      last_result  <= status.last_one;
      if (status.last_one) begin
        total_wait       <= totw_cur[psw_pkg::TOTW_W-1:0];
        total_turnaround <= tott_cur[psw_pkg::TOTT_W-1:0];
      end else begin
        total_wait       <= '0;
        total_turnaround <= '0;
      end
    end
  end

endmodule

/* rtl/core/priority_schedule_wait_times_top.sv */
// ---------------------------------------------------------------------------
// priority_schedule_wait_times_top
// Non-preemptive priority scheduler: collects a set of jobs, orders them by
// ascending priority value (ties kept in arrival order) and returns one
// result request per job with waiting and turnaround times.
// ---------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  ---------------------------------------
//   in       in_valid / in_stall   burst_time, job_priority, last_job
//   out      out_valid / out_stall job_id, out_priority, out_burst,
//                                  wait_time, turnaround, total_wait,
//                                  total_turnaround, overflow, last_result
//
// Operation: each accepted job request goes straight into the store; the insertion cells keep the
// store sorted as jobs arrive, so no separate sort phase follows. A set of
// N jobs then emits N results at one per cycle while the output is not stalled.
// The input is stalled from the last_job request until the final result has
// been moved into the output register.
// Reset (rst, synchronous) empties the job set and clears the running sums;
// no clearing pass is needed.
// An output stall simply holds the result register and pauses emission.
// Requests beyond MAX_PROCS jobs are dropped and flag overflow.
// ---------------------------------------------------------------------------
module priority_schedule_wait_times_top #(
  parameter int MAX_PROCS  = 32,
  parameter int BURST_BITS = 16,
  parameter int PRIO_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // job requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [BURST_BITS-1:0]       burst_time,
  input  logic [PRIO_BITS-1:0]        job_priority,
  input  logic                        last_job,
  // schedule results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psw_pkg::ID_W-1:0]    job_id,
  output logic [PRIO_BITS-1:0]        out_priority,
  output logic [BURST_BITS-1:0]       out_burst,
  output logic [psw_pkg::WAIT_W-1:0]  wait_time,
  output logic [psw_pkg::WAIT_W-1:0]  turnaround,
  output logic [psw_pkg::TOTW_W-1:0]  total_wait,
  output logic [psw_pkg::TOTT_W-1:0]  total_turnaround,
  output logic                        overflow,
  output logic                        last_result
);

  psw_pkg::psw_cmd_t    cmd;
  psw_pkg::psw_status_t status;

  // sequencer: load phase, then emit phase
  psw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_job  (last_job),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // ordered store, prefix sums and result register
  psw_dp #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS),
    .PRIO_BITS  (PRIO_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .burst_time       (burst_time),
    .job_priority     (job_priority),
    .status           (status),
    .job_id           (job_id),
    .out_priority     (out_priority),
    .out_burst        (out_burst),
    .wait_time        (wait_time),
    .turnaround       (turnaround),
    .total_wait       (total_wait),
    .total_turnaround (total_turnaround),
    .overflow         (overflow),
    .last_result      (last_result)
  );

  // turnaround is always waiting time plus own burst
  a_turn_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turnaround ==
      psw_pkg::WAIT_W'(wait_time + psw_pkg::WAIT_W'(out_burst)))
    else $error("turnaround does not match wait plus burst");

  // totals only on the final result
  a_tot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> (total_wait == '0 && total_turnaround == '0))
    else $error("totals set on a non-final result");

  // a closing job request always starts emission
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_job) |=> (in_stall && cmd.emit == !(out_valid && out_stall)))
    else $error("emission did not start after last job");

endmodule
